### design/b32d_pkg.sv
// b32d_pkg: types and constants shared by the base32 stream decoder
// no dependencies; used by the interfaces and every decoder module
`timescale 1ns / 1ps

package b32d_pkg;

  localparam logic [7:0] InvalidFrom = 8'h7F;
  localparam logic [7:0] DashChar    = 8'h2D;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } b32d_status_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } b32d_item_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         byte_valid;
    logic         end_of_message;
    b32d_status_e status;
  } b32d_result_t;

  typedef struct packed {
    logic [4:0] value;
    logic       is_dash;
    logic       is_bad;
  } b32d_sym_t;

endpackage

### design/b32d_if.sv
// b32d_in_if / b32d_out_if: valid-ready channels of the base32 decoder
// depends on b32d_pkg for the beat payload types
`timescale 1ns / 1ps

interface b32d_in_if ();
  logic                valid;
  logic                ready;
  b32d_pkg::b32d_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface b32d_out_if ();
  logic                  valid;
  logic                  ready;
  b32d_pkg::b32d_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/base32_stream_decoder.sv
// order: an accepted input beat waits in the input register; any result beat it yields then goes to the result register
// throughput: one input beat per cycle; the input register and the result
//   register both advance every cycle the result side is free or draining
// reset: rst_ni clears message state, discard flag and both valid flags
// base32_stream_decoder top level; depends on b32d_pkg, b32d_if,
//   b32d_sym_lut and b32d_packer
`timescale 1ns / 1ps

module base32_stream_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  b32d_in_if.sink           in_i,
  b32d_out_if.source        out_o
);

  logic                   in_vld_q;
  b32d_pkg::b32d_item_t   in_q;
  logic                   out_vld_q;
  b32d_pkg::b32d_result_t out_q;

  logic                   adv;
  b32d_pkg::b32d_sym_t    sym;
  logic                   res_vld;
  b32d_pkg::b32d_result_t res;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  b32d_sym_lut u_sym_lut (
    .ch_i  (in_q.symbol),
    .sym_o (sym)
  );

  b32d_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .item_i    (in_q),
    .sym_i     (sym),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

endmodule

### design/b32d_sym_lut.sv
// b32d_sym_lut: maps one character to its 5-bit symbol, dash and invalid flags
// depends on b32d_pkg
`timescale 1ns / 1ps

module b32d_sym_lut (
  input  logic [7:0]          ch_i,
  output b32d_pkg::b32d_sym_t sym_o
);

  logic [4:0] idx;
  logic       is_letter;
  logic       is_digit;

  assign idx       = ch_i[4:0];
  assign is_letter = ((ch_i[7:5] == 3'b010) || (ch_i[7:5] == 3'b011)) &&
                     (idx >= 5'd1) && (idx <= 5'd26);
  assign is_digit  = (ch_i >= 8'h30) && (ch_i <= 8'h39);

  always_comb begin
    sym_o.value   = 5'd0;
    sym_o.is_dash = (ch_i == b32d_pkg::DashChar);
    sym_o.is_bad  = (ch_i >= b32d_pkg::InvalidFrom);
    if (is_digit) begin
      sym_o.value = {1'b0, ch_i[3:0]};
    end else if (is_letter) begin
      // letters skip i, l, o, u; i and l read as one
      case (idx) inside
        [5'd1:5'd8]:   sym_o.value = idx + 5'd9;
        5'd9, 5'd12:   sym_o.value = 5'd1;
        [5'd10:5'd11]: sym_o.value = idx + 5'd8;
        [5'd13:5'd14]: sym_o.value = idx + 5'd7;
        [5'd16:5'd20]: sym_o.value = idx + 5'd6;
        [5'd22:5'd26]: sym_o.value = idx + 5'd5;
        default:       sym_o.value = 5'd0;
      endcase
    end
  end

endmodule

### design/b32d_packer.sv
// b32d_packer: message state, symbol packing and end status for one beat
// depends on b32d_pkg; fed by b32d_sym_lut
`timescale 1ns / 1ps

module b32d_packer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  b32d_pkg::b32d_item_t   item_i,
  input  b32d_pkg::b32d_sym_t    sym_i,
  output logic                   res_vld_o,
  output b32d_pkg::b32d_result_t res_o
);

  logic [6:0]  acc_q, acc_d;
  logic [2:0]  bits_q, bits_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;

  logic [11:0] acc_sh;
  logic [3:0]  bits_sum;
  logic [2:0]  bits_left;
  logic [11:0] keep_mask;
  logic [11:0] byte_sh;
  logic [2:0]  cnt_inc;

  always_comb begin
    acc_sh    = {acc_q, sym_i.value};
    bits_sum  = {1'b0, bits_q} + 4'd5;
    bits_left = bits_sum[2:0];
    keep_mask = (12'd1 << bits_left) - 12'd1;
    byte_sh   = acc_sh >> bits_left;
    cnt_inc   = cnt_q + 3'd1;
  end

  always_comb begin
    acc_d     = acc_q;
    bits_d    = bits_q;
    cnt_d     = cnt_q;
    disc_d    = disc_q;
    res_vld_o = 1'b0;
    res_o     = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_message: 1'b0,
                  status: b32d_pkg::STATUS_OK};
    if (disc_q) begin
      disc_d = !item_i.last;
    end else if (sym_i.is_bad) begin
      acc_d     = 7'd0;
      bits_d    = 3'd0;
      cnt_d     = 3'd0;
      disc_d    = !item_i.last;
      res_vld_o = 1'b1;
      res_o.end_of_message = 1'b1;
      res_o.status         = b32d_pkg::STATUS_BAD_CHAR;
    end else begin
      if (!sym_i.is_dash) begin
        cnt_d = cnt_inc;
        if (bits_sum[3]) begin
          bits_d           = bits_left;
          acc_d            = acc_sh[6:0] & keep_mask[6:0];
          res_o.data_byte  = byte_sh[7:0];
          res_o.byte_valid = 1'b1;
        end else begin
          bits_d = bits_left;
          acc_d  = acc_sh[6:0];
        end
      end
      res_vld_o = res_o.byte_valid;
      if (item_i.last) begin
        res_vld_o            = 1'b1;
        res_o.end_of_message = 1'b1;
        if (cnt_d inside {3'd1, 3'd3, 3'd6}) begin
          res_o.status = b32d_pkg::STATUS_BAD_LEN;
        end
        acc_d  = 7'd0;
        bits_d = 3'd0;
        cnt_d  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 7'd0;
      bits_q <= 3'd0;
      cnt_q  <= 3'd0;
      disc_q <= 1'b0;
    end else if (adv_i) begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
    end
  end

`ifndef ASSERT_OFF
  a_bad_char_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !disc_q && sym_i.is_bad && !item_i.last |=> disc_q)
    else $error("invalid character did not start discarding");

  a_error_ends_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && (res_o.status != b32d_pkg::STATUS_OK) |-> res_o.end_of_message)
    else $error("error status without end of message");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.last |=> (acc_q == 7'd0) && (bits_q == 3'd0) && (cnt_q == 3'd0))
    else $error("message state not cleared after last beat");
`endif

endmodule

### sim/tb_top.sv
// tb_top: self-checking bench for base32_stream_decoder with random idling on both channels
// depends on b32d_pkg, b32d_if and the decoder top level; a scoreboard class predicts each beat
`timescale 1ns / 1ps

module tb_top;

  localparam int    StallLimit  = 2000;
  localparam int    TargetBeats = 1150;
  localparam string Base32Alpha = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
  localparam string AliasChars  = "ILOUilou";

  class decode_scoreboard;
    logic [11:0]            acc;
    logic [3:0]             held;
    logic [2:0]             sym_count;
    bit                     discarding;
    b32d_pkg::b32d_result_t waiting[$];
    int                     errors;
    int                     live_beats;

    function new();
      acc        = '0;
      held       = '0;
      sym_count  = '0;
      discarding = 1'b0;
      errors     = 0;
      live_beats = 0;
    endfunction

    function logic [4:0] lookup(logic [7:0] ch);
      logic [7:0] up;
      up = ch;
      if (ch >= "a" && ch <= "z") up = ch - 8'h20;
      if (up >= "0" && up <= "9") return 5'(up - "0");
      if (up >= "A" && up <= "Z") begin
        if (up == "I" || up == "L") return 5'd1;
        if (up == "O" || up == "U") return 5'd0;
        return 5'(10 + (up - "A") - (up > "I") - (up > "L") - (up > "O") - (up > "U"));
      end
      return 5'd0;
    endfunction

    function void clear_message();
      acc       = '0;
      held      = '0;
      sym_count = '0;
    endfunction

    function void note_beat(b32d_pkg::b32d_item_t item);
      b32d_pkg::b32d_result_t res;
      logic                   byte_done;
      logic [7:0]             data;
      res        = '0;
      res.status = b32d_pkg::STATUS_OK;
      byte_done  = 1'b0;
      data       = '0;
      if (discarding) begin
        if (item.last) discarding = 1'b0;
        return;
      end
      live_beats++;
      if (item.symbol >= b32d_pkg::InvalidFrom) begin
        clear_message();
        discarding         = !item.last;
        res.end_of_message = 1'b1;
        res.status         = b32d_pkg::STATUS_BAD_CHAR;
        waiting.push_back(res);
        return;
      end
      if (item.symbol != b32d_pkg::DashChar) begin
        acc       = {acc[6:0], lookup(item.symbol)};
        held      = held + 4'd5;
        sym_count = sym_count + 3'd1;
        if (held >= 4'd8) begin
          held      = held - 4'd8;
          data      = 8'(acc >> held);
          byte_done = 1'b1;
          acc       = acc & ((12'd1 << held) - 12'd1);
        end
      end
      if (!item.last) begin
        if (byte_done) begin
          res.data_byte  = data;
          res.byte_valid = 1'b1;
          waiting.push_back(res);
        end
        return;
      end
      res.data_byte      = data;
      res.byte_valid     = byte_done;
      res.end_of_message = 1'b1;
      res.status = (sym_count == 3'd1 || sym_count == 3'd3 || sym_count == 3'd6) ?
                   b32d_pkg::STATUS_BAD_LEN : b32d_pkg::STATUS_OK;
      clear_message();
      waiting.push_back(res);
    endfunction

    function void report(string field, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, field, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_beat(b32d_pkg::b32d_result_t got);
      b32d_pkg::b32d_result_t exp;
      if (waiting.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, got);
        errors++;
        return;
      end
      exp = waiting.pop_front();
      report("data_byte", exp.data_byte, got.data_byte);
      report("byte_valid", exp.byte_valid, got.byte_valid);
      report("end_of_message", exp.end_of_message, got.end_of_message);
      report("status", exp.status, got.status);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   sender_eager;
  bit   sink_eager;
  int   idle_cycles;

  decode_scoreboard sb = new();

  b32d_in_if  in_if ();
  b32d_out_if out_if ();

  base32_stream_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(bit eager);
    return eager ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] pick_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return Base32Alpha[$urandom_range(0, 31)];
    if (pick < 58) return 8'($urandom_range("a", "z"));
    if (pick < 68) return AliasChars[$urandom_range(0, 7)];
    if (pick < 78) return b32d_pkg::DashChar;
    return 8'($urandom_range(0, b32d_pkg::InvalidFrom - 1));
  endfunction

  task automatic send_beat(logic [7:0] sym, logic is_last);
    int gap;
    gap = draw_wait(sender_eager);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{symbol: sym, last: is_last};
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) send_beat(text[i], i == text.len() - 1);
  endtask

  task automatic send_message(int len, int bad_at);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = (i == bad_at) ? 8'($urandom_range(b32d_pkg::InvalidFrom, 255)) : pick_char();
      send_beat(ch, i == len - 1);
    end
  endtask

  task automatic send_noise(int count);
    for (int i = 0; i < count; i++)
      send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // hold off input until every predicted result is out
  task automatic drain_pause();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting.size() != 0);
  endtask

  initial begin
    int msg_count;
    int kind;
    int len;
    int tail_cycles;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    sender_eager   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-ones bytes with a byte on last, short message, aliases with dash on last
    send_text("ZZZZZZZZ");
    send_text("0");
    send_text("ilOu-");
    // bad character mid-message then dropped beats up to last
    send_beat("A", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("B", 1'b0);
    send_beat("C", 1'b1);
    send_beat(b32d_pkg::InvalidFrom, 1'b1);
    send_beat(8'h80, 1'b0);
    send_beat(b32d_pkg::DashChar, 1'b1);
    // unlisted characters map to zero, three symbols give a bad length
    send_beat("~", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat("z", 1'b1);
    drain_pause();

    msg_count = 0;
    while (sb.live_beats < TargetBeats) begin
      sender_eager = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        send_message($urandom_range(1, 20), -1);
      end else if (kind < 18) begin
        len = $urandom_range(1, 20);
        send_message(len, $urandom_range(0, len - 1));
      end else begin
        send_noise($urandom_range(1, 8));
      end
      msg_count++;
      if (msg_count == 30 || $urandom_range(0, 49) == 0) drain_pause();
    end
    in_if.valid <= 1'b0;

    tail_cycles = 0;
    while (sb.waiting.size() != 0 && tail_cycles < StallLimit) begin
      @(posedge clk);
      tail_cycles++;
    end
    if (sb.waiting.size() != 0) begin
      $display("[base32_stream_decoder] ERROR");
    end else begin
      repeat (8) @(posedge clk);
      if (sb.errors == 0) begin
        $display("[base32_stream_decoder] OK");
      end else begin
        $display("[base32_stream_decoder] ERROR");
      end
    end
    $finish;
  end

  initial begin
    int stall;
    int beats;
    out_if.ready <= 1'b0;
    sink_eager   = 1'b0;
    beats        = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (beats % 40 == 0) sink_eager = ($urandom_range(0, 4) == 0);
      stall = draw_wait(sink_eager);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      beats++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.payload);
      if (in_if.valid && in_if.ready) sb.note_beat(in_if.payload);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("[base32_stream_decoder] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
